### src/obu_pkg.sv
// shared types and constants for the oriented box decoder
package obu_pkg;

  // one packed box on the input channel
  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [7:0]         size_x;
    logic [7:0]         size_y;
    logic [7:0]         size_z;
    logic signed [15:0] angle_a;
    logic signed [15:0] angle_b;
    logic signed [15:0] angle_c;
    logic [31:0]        texel_scale;
  } box_in_t;

  // one matrix row result on the output channel
  typedef struct packed {
    logic [1:0]         row;
    logic signed [47:0] center_coord;
    logic [39:0]        extent;
    logic signed [15:0] rot_col0;
    logic signed [15:0] rot_col1;
    logic signed [15:0] rot_col2;
    logic               last;
  } row_out_t;

  typedef logic [1:0] row_idx_t;
  localparam row_idx_t RowFirst = 2'd0;
  localparam row_idx_t RowLast  = 2'd2;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgHeadX = 2'd0;
  localparam cfg_idx_t CfgHeadY = 2'd1;
  localparam cfg_idx_t CfgHeadZ = 2'd2;

  // pi in Q2.36
  localparam logic [37:0] PiQ36 = 38'h3243F6A888;

  // taylor series: term count, divisors and Q31 reciprocals
  localparam int NumTerms   = 7;
  localparam int SeriesLat  = 2 + 3 * NumTerms + 1;

  localparam logic [7:0] SinDiv [NumTerms] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
  };
  localparam logic [7:0] CosDiv [NumTerms] = '{
    8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
  };
  localparam logic [30:0] SinRecip [NumTerms] = '{
    31'(64'd2147483648 / 64'd6),   31'(64'd2147483648 / 64'd20),
    31'(64'd2147483648 / 64'd42),  31'(64'd2147483648 / 64'd72),
    31'(64'd2147483648 / 64'd110), 31'(64'd2147483648 / 64'd156),
    31'(64'd2147483648 / 64'd210)
  };
  localparam logic [30:0] CosRecip [NumTerms] = '{
    31'(64'd2147483648 / 64'd2),   31'(64'd2147483648 / 64'd12),
    31'(64'd2147483648 / 64'd30),  31'(64'd2147483648 / 64'd56),
    31'(64'd2147483648 / 64'd90),  31'(64'd2147483648 / 64'd132),
    31'(64'd2147483648 / 64'd182)
  };

endpackage

### src/obu_series.sv
// pipelined sine and cosine series for one reduced angle
module obu_series (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] q_i,
  output logic [16:0] sin_o,
  output logic [16:0] cos_o
);
  import obu_pkg::*;

  logic [52:0] xprod;
  logic [60:0] x2prod;
  logic [29:0] x_q;
  logic [29:0] xb_q;
  logic [29:0] x2_q;
  logic [31:0] sin_rnd;
  logic [31:0] cos_rnd;
  logic [16:0] sin_q;
  logic [16:0] cos_q;

  // chain between term stages
  logic [30:0] st [NumTerms+1];
  logic [30:0] ss [NumTerms+1];
  logic [30:0] ct [NumTerms+1];
  logic [30:0] cs [NumTerms+1];
  logic [29:0] xx [NumTerms+1];

  // angle in Q2.30, then its square
  assign xprod  = 53'(q_i) * 53'(PiQ36) + 53'd2097152;
  assign x2prod = 61'(x_q) * 61'(x_q) + 61'd536870912;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= xprod[51:22];
      xb_q <= x_q;
      x2_q <= x2prod[59:30];
    end
  end

  assign st[0] = {1'b0, xb_q};
  assign ss[0] = {1'b0, xb_q};
  assign ct[0] = 31'h40000000;
  assign cs[0] = 31'h40000000;
  assign xx[0] = x2_q;

  // one series term: multiply, reciprocal multiply, correct and accumulate
  for (genvar j = 0; j < NumTerms; j++) begin : g_term
    localparam bit Sub = (j % 2 == 0);
    logic [60:0] sprod;
    logic [60:0] cprod;
    logic [61:0] sdiv;
    logic [61:0] cdiv;
    logic [38:0] srem;
    logic [38:0] crem;
    logic [30:0] sfix;
    logic [30:0] cfix;
    logic [30:0] sn_q, cn_q, ssp_q, csp_q;
    logic [29:0] x2p_q;
    logic [30:0] sq_q, cq_q, snd_q, cnd_q, ssd_q, csd_q;
    logic [29:0] x2d_q;
    logic [30:0] st_q, ss_q, ct_q, cs_q;
    logic [29:0] x2c_q;

    assign sprod = 61'(st[j]) * 61'(xx[j]);
    assign cprod = 61'(ct[j]) * 61'(xx[j]);
    assign sdiv  = 62'(sn_q) * 62'(SinRecip[j]);
    assign cdiv  = 62'(cn_q) * 62'(CosRecip[j]);
    assign srem  = 39'(snd_q) - 39'(sq_q) * 39'(SinDiv[j]);
    assign crem  = 39'(cnd_q) - 39'(cq_q) * 39'(CosDiv[j]);
    assign sfix  = sq_q + 31'(srem >= 39'(SinDiv[j]));
    assign cfix  = cq_q + 31'(crem >= 39'(CosDiv[j]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q  <= sprod[60:30];
        cn_q  <= cprod[60:30];
        ssp_q <= ss[j];
        csp_q <= cs[j];
        x2p_q <= xx[j];
        sq_q  <= sdiv[61:31];
        cq_q  <= cdiv[61:31];
        snd_q <= sn_q;
        cnd_q <= cn_q;
        ssd_q <= ssp_q;
        csd_q <= csp_q;
        x2d_q <= x2p_q;
        st_q  <= sfix;
        ct_q  <= cfix;
        ss_q  <= Sub ? ssd_q - sfix : ssd_q + sfix;
        cs_q  <= Sub ? csd_q - cfix : csd_q + cfix;
        x2c_q <= x2d_q;
      end
    end

    assign st[j+1] = st_q;
    assign ss[j+1] = ss_q;
    assign ct[j+1] = ct_q;
    assign cs[j+1] = cs_q;
    assign xx[j+1] = x2c_q;
  end

  // round Q2.30 to Q1.15
  assign sin_rnd = 32'(ss[NumTerms]) + 32'd16384;
  assign cos_rnd = 32'(cs[NumTerms]) + 32'd16384;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_rnd[31:15];
      cos_q <= cos_rnd[31:15];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### src/oriented_box_unpack.sv
// oriented box decoder top level: center, extents and rotation rows
// A box is taken in every cycle while the pipeline moves; its three row results
// leave one row a cycle while out_stall_i is low, so the output row serializer
// sets the sustained box rate. The depth is set by the seven-term sine and
// cosine series (three stages a term) followed by the matrix product stages.
// in_stall_o rises only when a finished box waits for the serializer. The head
// center registers must be written only while the block is idle; it does not enforce this.
module oriented_box_unpack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  obu_pkg::box_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output obu_pkg::row_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [47:0]       cfg_wdata_i
);
  import obu_pkg::*;

  localparam int NumStages = SeriesLat + 6;
  localparam int FixIdx    = SeriesLat;

  typedef struct packed {
    logic [2:0][47:0] center;
    logic [2:0][39:0] extent;
    logic [2:0][1:0]  quad;
    logic [2:0]       swap;
  } side_t;

  logic [47:0] hc_q [3];

  side_t       side_d;
  side_t       side_q [NumStages];
  logic        vld_q  [NumStages];
  logic [14:0] q_d    [3];
  logic [14:0] q_q    [3];
  logic [16:0] sin_w  [3];
  logic [16:0] cos_w  [3];

  logic adv;
  logic load;
  logic out_xfer;
  logic ser_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q[0] <= '0;
      hc_q[1] <= '0;
      hc_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeadX: hc_q[0] <= cfg_wdata_i;
        CfgHeadY: hc_q[1] <= cfg_wdata_i;
        CfgHeadZ: hc_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input stage: center, extent and angle reduction
  always_comb begin
    logic signed [15:0] off [3];
    logic [7:0]         sz  [3];
    logic [16:0]        ph  [3];
    logic signed [32:0] scl;
    logic signed [48:0] mul;
    logic signed [49:0] sum;
    logic [14:0]        r;
    off[0] = in_data_i.offset_x;
    off[1] = in_data_i.offset_y;
    off[2] = in_data_i.offset_z;
    sz[0]  = in_data_i.size_x;
    sz[1]  = in_data_i.size_y;
    sz[2]  = in_data_i.size_z;
    ph[0]  = {in_data_i.angle_a, 1'b0};
    ph[1]  = {in_data_i.angle_b[15], in_data_i.angle_b};
    ph[2]  = {in_data_i.angle_c, 1'b0};
    scl    = {1'b0, in_data_i.texel_scale};
    side_d = '0;
    for (int k = 0; k < 3; k++) begin
      mul = off[k] * scl;
      sum = 50'(mul) + 50'($signed(hc_q[k]));
      if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) begin
        side_d.center[k] = sum[47:0];
      end else if (sum[49]) begin
        side_d.center[k] = {1'b1, 47'd0};
      end else begin
        side_d.center[k] = {1'b0, {47{1'b1}}};
      end
      side_d.extent[k] = 40'(sz[k]) * 40'(in_data_i.texel_scale);
      r                = ph[k][14:0];
      side_d.swap[k]   = r > 15'd16384;
      side_d.quad[k]   = ph[k][16:15];
      q_d[k]           = side_d.swap[k] ? 15'(16'd32768 - {1'b0, r}) : r;
    end
  end

  // pipeline enable and valid chain
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign ser_free   = !out_valid_o || (out_xfer && out_data_o.row == RowLast);
  assign adv        = !vld_q[NumStages-1] || ser_free;
  assign load       = adv && vld_q[NumStages-1];
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStages; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < NumStages; i++) side_q[i] <= side_q[i-1];
      for (int k = 0; k < 3; k++) q_q[k] <= q_d[k];
    end
  end

  // series units, one per angle
  for (genvar k = 0; k < 3; k++) begin : g_ang
    obu_series u_series (
      .clk_i (clk_i),
      .en_i  (adv),
      .q_i   (q_q[k]),
      .sin_o (sin_w[k]),
      .cos_o (cos_w[k])
    );
  end

  // quadrant unfold into signed sine and cosine
  logic signed [17:0] sv_q [3];
  logic signed [17:0] cv_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [17:0] bs;
        logic signed [17:0] bc;
        bs = side_q[FixIdx].swap[k] ? $signed({1'b0, cos_w[k]}) : $signed({1'b0, sin_w[k]});
        bc = side_q[FixIdx].swap[k] ? $signed({1'b0, sin_w[k]}) : $signed({1'b0, cos_w[k]});
        unique case (side_q[FixIdx].quad[k])
          2'd0: begin sv_q[k] <= bs;  cv_q[k] <= bc;  end
          2'd1: begin sv_q[k] <= bc;  cv_q[k] <= -bs; end
          2'd2: begin sv_q[k] <= -bs; cv_q[k] <= -bc; end
          default: begin sv_q[k] <= -bc; cv_q[k] <= bs; end
        endcase
      end
    end
  end

  // pairwise products
  logic signed [35:0] c0c2_q, c1s0_q, c0c1_q, c2s0_q, s2s1_q, c0s2_q;
  logic signed [35:0] c2c1_q, s0s2_q, c2s1_q, s1s0_q, c0s1_q;
  logic signed [17:0] s0_m_q, s2_m_q, c2_m_q, c1_m_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0c2_q <= cv_q[0] * cv_q[2];
      c1s0_q <= cv_q[1] * sv_q[0];
      c0c1_q <= cv_q[0] * cv_q[1];
      c2s0_q <= cv_q[2] * sv_q[0];
      s2s1_q <= sv_q[2] * sv_q[1];
      c0s2_q <= cv_q[0] * sv_q[2];
      c2c1_q <= cv_q[2] * cv_q[1];
      s0s2_q <= sv_q[0] * sv_q[2];
      c2s1_q <= cv_q[2] * sv_q[1];
      s1s0_q <= sv_q[1] * sv_q[0];
      c0s1_q <= cv_q[0] * sv_q[1];
      s0_m_q <= sv_q[0];
      s2_m_q <= sv_q[2];
      c2_m_q <= cv_q[2];
      c1_m_q <= cv_q[1];
    end
  end

  // triple products, pairs carried along
  logic signed [53:0] c1s0s2_q, c0c1s2_q, c2c1s0_q, c0c1c2_q;
  logic signed [35:0] c0c2_t_q, c2s0_t_q, s2s1_t_q, c0s2_t_q;
  logic signed [35:0] s0s2_t_q, c2s1_t_q, s1s0_t_q, c0s1_t_q;
  logic signed [17:0] c1_t_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1s0s2_q <= c1s0_q * s2_m_q;
      c0c1s2_q <= c0c1_q * s2_m_q;
      c2c1s0_q <= c2c1_q * s0_m_q;
      c0c1c2_q <= c0c1_q * c2_m_q;
      c0c2_t_q <= c0c2_q;
      c2s0_t_q <= c2s0_q;
      s2s1_t_q <= s2s1_q;
      c0s2_t_q <= c0s2_q;
      s0s2_t_q <= s0s2_q;
      c2s1_t_q <= c2s1_q;
      s1s0_t_q <= s1s0_q;
      c0s1_t_q <= c0s1_q;
      c1_t_q   <= c1_m_q;
    end
  end

  // Q45 entries plus the rounding half
  logic signed [49:0] w_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [49:0] h;
      h = 50'sd536870912;
      w_q[0][0] <= (50'(c0c2_t_q) <<< 15) - 50'(c1s0s2_q) + h;
      w_q[0][1] <= 50'(c0c1s2_q) + (50'(c2s0_t_q) <<< 15) + h;
      w_q[0][2] <= (50'(s2s1_t_q) <<< 15) + h;
      w_q[1][0] <= -(50'(c0s2_t_q) <<< 15) - 50'(c2c1s0_q) + h;
      w_q[1][1] <= 50'(c0c1c2_q) - (50'(s0s2_t_q) <<< 15) + h;
      w_q[1][2] <= (50'(c2s1_t_q) <<< 15) + h;
      w_q[2][0] <= (50'(s1s0_t_q) <<< 15) + h;
      w_q[2][1] <= -(50'(c0s1_t_q) <<< 15) + h;
      w_q[2][2] <= (50'(c1_t_q) <<< 30) + h;
    end
  end

  // floor to Q15 and saturate
  logic signed [15:0] rot_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [19:0] rr;
          rr = 20'(w_q[i][j] >>> 30);
          if (rr[19:15] == 5'b00000 || rr[19:15] == 5'b11111) begin
            rot_q[i][j] <= rr[15:0];
          end else if (rr[19]) begin
            rot_q[i][j] <= 16'sh8000;
          end else begin
            rot_q[i][j] <= 16'sh7fff;
          end
        end
      end
    end
  end

  // output row serializer
  logic               ser_vld_q;
  row_idx_t           ser_row_q;
  side_t              ser_side_q;
  logic signed [15:0] ser_rot_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      ser_row_q <= RowFirst;
    end else if (load) begin
      ser_vld_q <= 1'b1;
      ser_row_q <= RowFirst;
    end else if (out_xfer) begin
      if (ser_row_q == RowLast) begin
        ser_vld_q <= 1'b0;
        ser_row_q <= RowFirst;
      end else begin
        ser_row_q <= ser_row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_side_q <= side_q[NumStages-1];
      ser_rot_q  <= rot_q;
    end
  end

  // present the current row
  always_comb begin
    out_data_o.row  = ser_row_q;
    out_data_o.last = ser_row_q == RowLast;
    unique case (ser_row_q)
      2'd1: begin
        out_data_o.center_coord = ser_side_q.center[1];
        out_data_o.extent       = ser_side_q.extent[1];
        out_data_o.rot_col0     = ser_rot_q[1][0];
        out_data_o.rot_col1     = ser_rot_q[1][1];
        out_data_o.rot_col2     = ser_rot_q[1][2];
      end
      2'd2: begin
        out_data_o.center_coord = ser_side_q.center[2];
        out_data_o.extent       = ser_side_q.extent[2];
        out_data_o.rot_col0     = ser_rot_q[2][0];
        out_data_o.rot_col1     = ser_rot_q[2][1];
        out_data_o.rot_col2     = ser_rot_q[2][2];
      end
      default: begin
        out_data_o.center_coord = ser_side_q.center[0];
        out_data_o.extent       = ser_side_q.extent[0];
        out_data_o.rot_col0     = ser_rot_q[0][0];
        out_data_o.rot_col1     = ser_rot_q[0][1];
        out_data_o.rot_col2     = ser_rot_q[0][2];
      end
    endcase
  end

  assign out_valid_o = ser_vld_q;

  // checks
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_vld_q |-> ser_row_q <= RowLast)
    else $error("row index past last row");

  a_load_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> ser_vld_q && ser_row_q == RowFirst)
    else $error("loaded box does not start at first row");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && ser_row_q == RowLast && !load) |=> !ser_vld_q)
    else $error("serializer still valid after last row transfer");

  a_cfg_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CfgHeadX) |=> hc_q[0] == $past(cfg_wdata_i))
    else $error("head center x not written");

endmodule

### dv/obu_row_checker.sv
// row result predictor and scoreboard for the oriented box decoder
`timescale 1ns / 100ps

module obu_row_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  obu_pkg::box_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  obu_pkg::row_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [47:0]       cfg_wdata_i,
  output int                errors_o,
  output int                pending_o
);
  import obu_pkg::*;

  localparam longint unsigned PiFix = 64'h3243F6A888;
  localparam longint CenterMax = 64'sd140737488355327;
  localparam longint CenterMin = -64'sd140737488355328;

  logic signed [47:0] head_q [3];
  row_out_t row_q [$];

  // taylor series of sine and cosine for q * pi / 65536, q in 0..16384
  function automatic void taylor(input longint unsigned q, output int sin_v, output int cos_v);
    longint unsigned x, x2, term, acc;
    x = (q * PiFix + (64'd1 << 21)) >> 22;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    sin_v = int'((acc + (64'd1 << 14)) >> 15);
    term = 64'd1 << 30;
    acc = term;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    cos_v = int'((acc + (64'd1 << 14)) >> 15);
  endfunction

  // quadrant folding of a 17-bit phase in units of pi / 65536
  function automatic void sin_cos(input logic [16:0] ph, output longint sin_v,
                                  output longint cos_v);
    int bs, bc;
    longint unsigned r;
    r = ph[14:0];
    if (r <= 16384) taylor(r, bs, bc);
    else taylor(32768 - r, bc, bs);
    case (ph[16:15])
      2'd0: begin sin_v = bs;  cos_v = bc;  end
      2'd1: begin sin_v = bc;  cos_v = -bc + bc - bs; end
      2'd2: begin sin_v = -bs; cos_v = -bc; end
      default: begin sin_v = -bc; cos_v = bs; end
    endcase
  endfunction

  // round a Q45 product to Q15, ties up, with saturation
  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // expected rows of one box
  task automatic predict_rows(input box_in_t b);
    longint s0, c0, s1, c1, s2, c2, ctr;
    logic signed [15:0] m [3][3];
    logic signed [15:0] offs [3];
    logic [7:0] sizes [3];
    longint unsigned sc;
    row_out_t r;
    sin_cos({b.angle_a, 1'b0}, s0, c0);
    sin_cos({b.angle_b[15], b.angle_b}, s1, c1);
    sin_cos({b.angle_c, 1'b0}, s2, c2);
    m[0][0] = round_q15(c0 * c2 * 32768 - c1 * s0 * s2);
    m[0][1] = round_q15(c1 * c0 * s2 + c2 * s0 * 32768);
    m[0][2] = round_q15(s2 * s1 * 32768);
    m[1][0] = round_q15(-c0 * s2 * 32768 - c2 * c1 * s0);
    m[1][1] = round_q15(c0 * c1 * c2 - s0 * s2 * 32768);
    m[1][2] = round_q15(c2 * s1 * 32768);
    m[2][0] = round_q15(s1 * s0 * 32768);
    m[2][1] = round_q15(-c0 * s1 * 32768);
    m[2][2] = round_q15(c1 * (64'sd1 <<< 30));
    offs = '{b.offset_x, b.offset_y, b.offset_z};
    sizes = '{b.size_x, b.size_y, b.size_z};
    sc = b.texel_scale;
    for (int k = 0; k < 3; k++) begin
      ctr = longint'(offs[k]) * longint'(sc) + longint'(head_q[k]);
      if (ctr > CenterMax) ctr = CenterMax;
      if (ctr < CenterMin) ctr = CenterMin;
      r.row = row_idx_t'(k);
      r.center_coord = 48'(ctr);
      r.extent = 40'(longint'(sizes[k]) * longint'(sc));
      r.rot_col0 = m[k][0];
      r.rot_col1 = m[k][1];
      r.rot_col2 = m[k][2];
      r.last = (row_idx_t'(k) == RowLast);
      row_q = {row_q, r};
    end
  endtask

  // track config writes, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    row_out_t e;
    if (!rst_ni) begin
      head_q = '{48'sd0, 48'sd0, 48'sd0};
      row_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHeadX) head_q[0] = cfg_wdata_i;
        else if (cfg_idx_i == CfgHeadY) head_q[1] = cfg_wdata_i;
        else if (cfg_idx_i == CfgHeadZ) head_q[2] = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) predict_rows(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (row_q.size() == 0) begin
          $display("%0t: unexpected row transfer, actual %p", $time, out_data_i);
          errors_o++;
        end else begin
          e = row_q.pop_front();
          if (e !== out_data_i) begin
            $display("%0t: row mismatch, expected %p, actual %p", $time, e, out_data_i);
            errors_o++;
          end
        end
      end
      pending_o = row_q.size();
    end
  end

endmodule

### dv/tb.sv
// stimulus, flow control and verdict for the oriented box decoder
`timescale 1ns / 100ps

module tb;
  import obu_pkg::*;

  localparam int Drain = 60;
  localparam int CycleLimit = 300000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  box_in_t in_data;
  row_out_t out_data;
  cfg_idx_t cfg_idx;
  logic [47:0] cfg_wdata;
  int errors, pending, cycles;
  bit hold_req;

  oriented_box_unpack i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  obu_row_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .errors_o(errors), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: segments of free flow, random stalls, long stalls, one long hold
  initial begin
    int seg, kind;
    bit held;
    out_stall = 1'b0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      seg = $urandom_range(5, 40);
      kind = $urandom_range(0, 9);
      repeat (seg) begin
        if (kind < 3) out_stall <= 1'b0;
        else if (kind < 9) out_stall <= ($urandom_range(0, 2) == 0);
        else out_stall <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_box(input box_in_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic set_heads(input logic [47:0] hx, input logic [47:0] hy,
                           input logic [47:0] hz);
    cfg_we <= 1'b1; cfg_idx <= CfgHeadX; cfg_wdata <= hx;
    @(posedge clk_i);
    cfg_idx <= CfgHeadY; cfg_wdata <= hy;
    @(posedge clk_i);
    cfg_idx <= CfgHeadZ; cfg_wdata <= hz;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] special [10] = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF,
                                  16'h2000, 16'hE000, 16'h6000, 16'h0001, 16'hFFFF};
    if ($urandom_range(0, 4) == 0) return special[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  function automatic box_in_t rand_box();
    box_in_t b;
    b.offset_x = 16'($urandom); b.offset_y = 16'($urandom); b.offset_z = 16'($urandom);
    b.size_x = 8'($urandom); b.size_y = 8'($urandom); b.size_z = 8'($urandom);
    b.angle_a = pick_angle(); b.angle_b = pick_angle(); b.angle_c = pick_angle();
    case ($urandom_range(0, 5))
      0: b.texel_scale = 32'hFFFFFFFF;
      1: b.texel_scale = $urandom_range(0, 255);
      2: b.texel_scale = 32'h0001_0000;
      default: b.texel_scale = $urandom;
    endcase
    return b;
  endfunction

  // stimulus
  initial begin
    box_in_t b;
    logic [15:0] dir_ang [8];
    dir_ang = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                16'hC000, 16'h2000, 16'h6000, 16'hA000};
    cycles = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CfgHeadX;
    cfg_wdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: angle quadrants with reset head center
    for (int i = 0; i < 8; i++) begin
      b.offset_x = 16'sh7FFF; b.offset_y = 16'sh8000; b.offset_z = 16'sd0;
      b.size_x = 8'hFF; b.size_y = 8'h00; b.size_z = 8'h80;
      b.angle_a = dir_ang[i]; b.angle_b = dir_ang[(i + 3) % 8];
      b.angle_c = dir_ang[(i + 5) % 8];
      b.texel_scale = (i % 2) ? 32'hFFFFFFFF : 32'h0001_0000;
      send_box(b);
    end
    settle();

    // directed: center saturation at both ends
    set_heads(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_0000);
    b = '{16'sh7FFF, 16'sh8000, 16'sh0001, 8'hFF, 8'hFF, 8'hFF,
          16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'hFFFFFFFF};
    send_box(b);
    b = '{16'sh8000, 16'sh7FFF, 16'sh8000, 8'h00, 8'h01, 8'hFE,
          16'sh0000, 16'sh7FFF, 16'sh8000, 32'h0000_0000};
    send_box(b);
    settle();
    set_heads(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    send_box(b);
    b.offset_x = 16'sh7FFF; b.offset_y = 16'sh8000; b.texel_scale = 32'hFFFFFFFF;
    send_box(b);
    settle();

    // random phases with differing head centers
    for (int p = 0; p < 4; p++) begin
      set_heads(48'($urandom) << ($urandom_range(0, 16)),
                {$urandom, 16'($urandom)}, p == 3 ? 48'd0 : {16'($urandom), $urandom});
      for (int i = 0; i < 50; i++) begin
        if (p == 1 && i == 10) hold_req = 1;
        if (p == 2 && i == 25) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_box(rand_box());
      end
      settle();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### oriented_box_unpack.f
src/obu_pkg.sv
src/obu_series.sv
src/oriented_box_unpack.sv
dv/obu_row_checker.sv
dv/tb.sv
